// File: rtl/six_axis_kalman_pose_smoother_macros.svh
// Assertion macros shared by the pose smoother RTL.
`ifndef SIX_AXIS_KALMAN_POSE_SMOOTHER_MACROS_SVH
`define SIX_AXIS_KALMAN_POSE_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SKPF_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SKPF_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/skpf_pkg.sv
// Shared types, constants and saturation helper for the pose smoother.
package skpf_pkg;

  localparam logic [46:0] NOISE_RESET = 47'd4294967296;
  localparam logic [46:0] ACCEL_RESET = 47'd42949673;
  localparam logic signed [47:0] INIT_COV = 48'sd4295;

  localparam logic [1:0] CFG_NOISE = 2'd0;
  localparam logic [1:0] CFG_ACCEL = 2'd1;

  localparam logic signed [51:0] MAX48_W = 52'sd140737488355327;
  localparam logic signed [51:0] MIN48_W = -52'sd140737488355328;
  localparam logic signed [47:0] MAX48 = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] MIN48 = 48'sh800000000000;

  // request to the multiply-divide unit: (a*b)/d
  typedef struct packed {
    logic              start;
    logic signed [49:0] a;
    logic signed [49:0] b;
    logic [47:0]       d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic signed [47:0] res;
  } md_rsp_t;

  // lane status seen by the merging stage
  typedef struct packed {
    logic              busy;
    logic signed [31:0] pred;
  } lane_stat_t;

  // clamp a widened sum to 48-bit signed
  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] o;
    if (v > MAX48_W) o = MAX48;
    else if (v < MIN48_W) o = MIN48;
    else o = v[47:0];
    return o;
  endfunction

endpackage

// File: rtl/skpf_muldiv.sv
// Sequential (a*b)/d unit: 17-bit digit multiply then radix-2 division, 2 bits a cycle.
module skpf_muldiv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  skpf_pkg::md_req_t    req,
  output skpf_pkg::md_rsp_t    rsp
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

  md_state_t          st_r;
  logic [5:0]         cnt_r;
  logic [48:0]        ma_r;
  logic [50:0]        mb_r;
  logic [97:0]        acc_r;
  logic [48:0]        rem_r;
  logic [46:0]        q_r;
  logic               big_r;
  logic               neg_r;
  logic [47:0]        d_r;
  logic               done_r;
  logic signed [47:0] res_r;

  logic [49:0]        abs_a, abs_b;
  logic [65:0]        prod;
  logic [97:0]        acc_nxt;
  logic [48:0]        rem_nxt;
  logic [97:0]        num_nxt;
  logic [46:0]        q_nxt;
  logic               big_nxt;
  logic signed [47:0] res_nxt;

  assign abs_a = req.a[49] ? 50'(-req.a) : 50'(req.a);
  assign abs_b = req.b[49] ? 50'(-req.b) : 50'(req.b);

  // one digit of the multiplier per cycle, top digit first
  assign prod    = ma_r * mb_r[50:34];
  assign acc_nxt = {acc_r[80:0], 17'b0} + {32'b0, prod};

  // two restoring division steps
  always_comb begin
    logic [48:0] r;
    logic [97:0] n;
    logic [46:0] q;
    logic        b;
    logic        ge;
    r = rem_r;
    n = acc_r;
    q = q_r;
    b = big_r;
    for (int k = 0; k < 2; k++) begin
      r  = {r[47:0], n[97]};
      n  = {n[96:0], 1'b0};
      ge = (r >= {1'b0, d_r});
      if (ge) r = r - {1'b0, d_r};
      b  = b | q[46];
      q  = {q[45:0], ge};
    end
    rem_nxt = r;
    num_nxt = n;
    q_nxt   = q;
    big_nxt = b;
  end

  // saturate the signed quotient
  always_comb begin
    if (big_nxt) res_nxt = neg_r ? skpf_pkg::MIN48 : skpf_pkg::MAX48;
    else if (neg_r) res_nxt = -$signed({1'b0, q_nxt});
    else res_nxt = $signed({1'b0, q_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (req.start) begin
            ma_r  <= abs_a[48:0];
            mb_r  <= {2'b0, abs_b[48:0]};
            neg_r <= req.a[49] ^ req.b[49];
            d_r   <= req.d;
            acc_r <= '0;
            rem_r <= '0;
            q_r   <= '0;
            big_r <= 1'b0;
            cnt_r <= '0;
            st_r  <= M_MUL;
          end
        end
        M_MUL: begin
          acc_r <= acc_nxt;
          mb_r  <= {mb_r[33:0], 17'b0};
          if (cnt_r == 6'd2) begin
            cnt_r <= '0;
            st_r  <= M_DIV;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        M_DIV: begin
          acc_r <= num_nxt;
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          big_r <= big_nxt;
          if (cnt_r == 6'd48) begin
            res_r  <= res_nxt;
            done_r <= 1'b1;
            cnt_r  <= '0;
            st_r   <= M_IDLE;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// File: rtl/skpf_lane.sv
// One axis: position/velocity state, predict step and correction sequencer.
module skpf_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   correct,
  input  logic signed [31:0]     meas,
  input  logic [46:0]            accel,
  input  logic [46:0]            noise,
  output skpf_pkg::lane_stat_t   stat
);

  typedef enum logic [1:0] {L_IDLE, L_CHK, L_WAIT} lane_state_t;
  typedef enum logic [2:0] {OP_X, OP_V, OP_P00, OP_P01, OP_P11} md_op_t;

  lane_state_t        st_r;
  md_op_t             op_r;
  logic signed [47:0] x_r, v_r, p00_r, p01_r, p11_r;
  logic signed [47:0] t00_r, t01_r;
  logic signed [49:0] y_r;
  logic signed [31:0] pred_r, meas_r;
  logic               corr_r;

  logic signed [47:0] xs, p00s, p01s, p11s;
  logic signed [48:0] s;
  logic               s_pos;
  logic signed [49:0] y;
  md_op_t             issue_op;
  skpf_pkg::md_req_t  req;
  skpf_pkg::md_rsp_t  rsp;

  // predict from the stored state
  assign xs   = skpf_pkg::sat48({{4{x_r[47]}}, x_r} + {{4{v_r[47]}}, v_r});
  assign p00s = skpf_pkg::sat48({{4{p00_r[47]}}, p00_r} + {{3{p01_r[47]}}, p01_r, 1'b0}
                + {{4{p11_r[47]}}, p11_r} + $signed({7'b0, accel[46:2]}));
  assign p01s = skpf_pkg::sat48({{4{p01_r[47]}}, p01_r} + {{4{p11_r[47]}}, p11_r}
                + $signed({6'b0, accel[46:1]}));
  assign p11s = skpf_pkg::sat48({{4{p11_r[47]}}, p11_r} + $signed({5'b0, accel}));

  // innovation variance and innovation
  assign s     = {p00_r[47], p00_r} + $signed({2'b0, noise});
  assign s_pos = !s[48] && (s != '0);
  assign y     = {{2{meas_r[31]}}, meas_r, 16'b0} - {{2{x_r[47]}}, x_r};

  // next op to hand to the divider
  always_comb begin
    issue_op = OP_X;
    if (st_r == L_WAIT) begin
      unique case (op_r)
        OP_X:    issue_op = OP_V;
        OP_V:    issue_op = OP_P00;
        OP_P00:  issue_op = OP_P01;
        OP_P01:  issue_op = OP_P11;
        OP_P11:  issue_op = OP_P11;
        default: issue_op = OP_X;
      endcase
    end
  end

  // operand select; the first op takes the innovation straight from the check cycle
  always_comb begin
    req.start = ((st_r == L_CHK) && corr_r && s_pos)
              || ((st_r == L_WAIT) && rsp.done && (op_r != OP_P11));
    req.d = s[47:0];
    unique case (issue_op)
      OP_X:    begin req.a = {{2{p00_r[47]}}, p00_r}; req.b = y; end
      OP_V:    begin req.a = {{2{p01_r[47]}}, p01_r}; req.b = y_r; end
      OP_P00:  begin req.a = {{2{p00_r[47]}}, p00_r}; req.b = $signed({3'b0, noise}); end
      OP_P01:  begin req.a = {{2{p01_r[47]}}, p01_r}; req.b = $signed({3'b0, noise}); end
      OP_P11:  begin req.a = {{2{p01_r[47]}}, p01_r}; req.b = {{2{p01_r[47]}}, p01_r}; end
      default: begin req.a = '0; req.b = '0; end
    endcase
  end

  skpf_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // state and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      op_r  <= OP_X;
      x_r   <= '0;
      v_r   <= '0;
      p00_r <= skpf_pkg::INIT_COV;
      p01_r <= '0;
      p11_r <= skpf_pkg::INIT_COV;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            x_r    <= xs;
            p00_r  <= p00s;
            p01_r  <= p01s;
            p11_r  <= p11s;
            pred_r <= xs[47:16];
            meas_r <= meas;
            corr_r <= correct;
            st_r   <= L_CHK;
          end
        end
        L_CHK: begin
          y_r <= y;
          if (corr_r && s_pos) begin
            op_r <= OP_X;
            st_r <= L_WAIT;
          end else begin
            st_r <= L_IDLE;
          end
        end
        L_WAIT: begin
          if (rsp.done) begin
            op_r <= issue_op;
            unique case (op_r)
              OP_X:   x_r   <= skpf_pkg::sat48({{4{x_r[47]}}, x_r}
                                 + {{4{rsp.res[47]}}, rsp.res});
              OP_V:   v_r   <= skpf_pkg::sat48({{4{v_r[47]}}, v_r}
                                 + {{4{rsp.res[47]}}, rsp.res});
              OP_P00: t00_r <= rsp.res;
              OP_P01: t01_r <= rsp.res;
              OP_P11: begin
                p11_r <= skpf_pkg::sat48({{4{p11_r[47]}}, p11_r}
                           - {{4{rsp.res[47]}}, rsp.res});
                p00_r <= t00_r;
                p01_r <= t01_r;
                st_r  <= L_IDLE;
              end
              default: st_r <= L_IDLE;
            endcase
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign stat.busy = (st_r != L_IDLE);
  assign stat.pred = pred_r;

endmodule

// File: rtl/six_axis_kalman_pose_smoother.sv
// Top level: config registers, AXES filter lanes and the merging output stage.
//
// Six-axis constant-velocity pose smoother. Each request on the input channel
// (in_valid/in_stall) carries six Q16.16 pose samples and a new-measurement
// flag; each lane predicts its axis and, with the flag set, corrects toward
// the sample. One result request per input goes out on out_valid/out_stall
// with the predicted poses.
// The predictions are registered in the lanes with the input and loaded into
// the output register once pend_r has cleared and the output is free. When
// predicting only, each lane just predicts and checks; with a correction each
// lane runs five multiply-divides on its own unit. All lanes run in parallel.
// in_stall stays high while any lane works or a result has not been loaded
// into the output register; a result waiting under out_stall does not block
// the next input once its own result is loaded.
// Reset (rst_n low, synchronous) restores R = 1.0, q = 0.01, zero estimates
// and cross-covariance, and variances of 1e-6; no clearing pass is needed.
// cfg_wr_en writes register cfg_index (0 noise, 1 accel) from cfg_wdata;
// other indexes are dropped. Write only while the block is idle.
`include "six_axis_kalman_pose_smoother_macros.svh"

module six_axis_kalman_pose_smoother #(
  parameter int AXES = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_meas_yaw,
  input  logic signed [31:0] in_meas_pitch,
  input  logic signed [31:0] in_meas_roll,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic signed [31:0] in_meas_z,
  input  logic               in_new_measurement,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pred_yaw,
  output logic signed [31:0] out_pred_pitch,
  output logic signed [31:0] out_pred_roll,
  output logic signed [31:0] out_pred_x,
  output logic signed [31:0] out_pred_y,
  output logic signed [31:0] out_pred_z,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [46:0]        cfg_wdata
);

  logic [46:0]          noise_r, accel_r;
  logic                 need_out_r, pend_r, out_valid_r;
  logic signed [31:0]   outp_r [6];

  logic signed [31:0]   pose [6];
  logic signed [31:0]   lane_pred6 [6];
  skpf_pkg::lane_stat_t stat [AXES];
  logic [AXES-1:0]      busy_v;
  logic                 any_busy, accept, place;

  assign pose[0] = in_meas_yaw;
  assign pose[1] = in_meas_pitch;
  assign pose[2] = in_meas_roll;
  assign pose[3] = in_meas_x;
  assign pose[4] = in_meas_y;
  assign pose[5] = in_meas_z;

  // filter lanes; axes past the pose fields see zero
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    logic signed [31:0] lane_meas;
    if (i < 6) begin : g_meas
      assign lane_meas = pose[i];
    end else begin : g_zero
      assign lane_meas = '0;
    end
    skpf_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (accept),
      .correct (in_new_measurement),
      .meas    (lane_meas),
      .accel   (accel_r),
      .noise   (noise_r),
      .stat    (stat[i])
    );
    assign busy_v[i] = stat[i].busy;
  end

  // pose fields without a lane read zero
  for (genvar j = 0; j < 6; j++) begin : g_out
    if (j < AXES) begin : g_lane_out
      assign lane_pred6[j] = stat[j].pred;
    end else begin : g_none
      assign lane_pred6[j] = '0;
    end
  end

  // merge lane status
  assign any_busy = |busy_v;
  assign in_stall = need_out_r || any_busy;
  assign accept   = in_valid && !in_stall;
  assign place    = need_out_r && !pend_r && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= skpf_pkg::NOISE_RESET;
      accel_r <= skpf_pkg::ACCEL_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == skpf_pkg::CFG_NOISE) noise_r <= cfg_wdata;
      else if (cfg_index == skpf_pkg::CFG_ACCEL) accel_r <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_out_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= accept;
      if (accept) need_out_r <= 1'b1;
      else if (place) need_out_r <= 1'b0;
      if (place) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      for (int k = 0; k < 6; k++) outp_r[k] <= lane_pred6[k];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pred_yaw   = outp_r[0];
  assign out_pred_pitch = outp_r[1];
  assign out_pred_roll  = outp_r[2];
  assign out_pred_x     = outp_r[3];
  assign out_pred_y     = outp_r[4];
  assign out_pred_z     = outp_r[5];

  `SKPF_ASSERT_NEXT(a_accept_blocks, clk, rst_n, accept, in_stall, "input taken twice")
  `SKPF_ASSERT_NOW(a_rose_from_pending, clk, rst_n, $rose(out_valid_r), $past(need_out_r), "result without request")
  `SKPF_ASSERT_NOW(a_busy_stalls, clk, rst_n, any_busy, in_stall, "input taken while lanes busy")
  `SKPF_ASSERT_NOW(a_no_place_in_pend, clk, rst_n, pend_r, !place, "result loaded before prediction")

endmodule
